@@ sv/oca_pkg.sv @@
// oca_pkg: types and constants shared by the octal-coded add/convert unit
// and its port checker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package oca_pkg;

    localparam int CODED_W    = 34;
    localparam int ADDEND_W   = 30;
    localparam int RESULT_W   = 35;
    localparam int SUM_W      = 31;
    localparam int OUT_DIGITS = 11;

    localparam logic [SUM_W-1:0]    SUM_MAX        = 31'h7FFF_FFFF;
    // SUM_MAX written as a decimal-coded octal number
    localparam logic [RESULT_W-1:0] SUM_MAX_CODED  = 35'd17777777777;
    localparam logic [4:0]          DEC_RADIX      = 5'd10;
    localparam logic [4:0]          DEC_DIGIT_MAX  = 5'd9;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIG_A,
        ST_DIG_B,
        ST_DIG_C,
        ST_SAT,
        ST_CONV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                func;
        logic [CODED_W-1:0]  octal_coded;
        logic [ADDEND_W-1:0] addend;
    } item_t;

    typedef struct packed {
        logic [RESULT_W-1:0] result;
        logic                overflow;
    } result_t;

endpackage

`default_nettype wire

@@ sv/octal_coded_add_convert_unit.sv @@
// octal_coded_add_convert_unit: octal-coded to binary conversion, add and
// saturate, optional conversion back to octal-coded form
// depends on oca_pkg
//
// usage
//   item channel (item_valid / item_ready / item) carries func, octal_coded
//   and addend; res channel (res_valid / res_ready / res) returns result and
//   overflow, one result per item, in order
//   the decimal digits of octal_coded are peeled off one at a time by a shared
//   divide-by-ten unit (reciprocal shift-add through ST_DIG_A, _B and _C) and
//   weighted by powers of eight into an accumulator preloaded with addend
//   digit extraction stops at IN_DIGITS digits or when the rest is zero
//   func 0 then packs the saturated sum into eleven octal digits, one per
//   cycle, through a times-ten-plus-digit adder
//   an item is taken only after the previous one has finished: the next item
//   is taken in the cycle the previous result first shows valid
//   item_ready is high only while no item is in work; one item at a time
//   the result sits in an output register, so a new item is taken while the
//   receiver stalls; a finished item waits only if that register is still full
//   reset clears the sequencer and the output valid, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module octal_coded_add_convert_unit
    import oca_pkg::*;
#(
    parameter int IN_DIGITS = 10
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_ready,
    input  wire item_t   item,
    output logic         res_valid,
    input  wire logic    res_ready,
    output result_t      res
);

    localparam int ACC_W = ((3 * IN_DIGITS + 1 > ADDEND_W) ? 3 * IN_DIGITS + 1 : ADDEND_W) + 1;
    localparam int SH_W  = (IN_DIGITS > 1) ? $clog2(3 * IN_DIGITS) : 1;
    localparam int CNT_W = ($clog2(IN_DIGITS + 1) > 4) ? $clog2(IN_DIGITS + 1) : 4;

    state_t               state_reg, state_next;
    logic                 res_valid_reg, res_valid_next;
    result_t              res_reg, res_next;

    logic                 func_reg, func_next;
    logic [CODED_W-1:0]   n_reg, n_next;
    logic [CODED_W-1:0]   t_reg, t_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [3:0]           digit_reg, digit_next;
    logic [SH_W-1:0]      sh_reg, sh_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [RESULT_W-1:0]  val_reg, val_next;
    logic                 ovf_reg, ovf_next;

    // divide-by-ten datapath
    logic [CODED_W-1:0]   q1, q2, q3, q4, q5, quo;
    logic [4:0]           rem5;
    logic                 rem_ge;
    logic [3:0]           dig;
    logic [ACC_W-1:0]     term;
    logic                 sat_ovf;
    logic [SUM_W-1:0]     sat_sum;
    logic [RESULT_W-1:0]  conv_val;

    always_comb
    begin
        q1   = (n_reg >> 1) + (n_reg >> 2);
        q2   = q1 + (q1 >> 4);
        q3   = t_reg + (t_reg >> 8);
        q4   = q3 + (q3 >> 16);
        q5   = t_reg + (t_reg >> 32);
        quo  = q5 >> 3;
        // remainder below twenty, so five bits are exact
        rem5 = n_reg[4:0] - {quo[1:0], 3'b000} - {quo[3:0], 1'b0};
        rem_ge = (rem5 > DEC_DIGIT_MAX);
        dig  = rem_ge ? 4'(rem5 - DEC_RADIX) : rem5[3:0];

        term = ACC_W'(digit_reg) << sh_reg;

        sat_ovf = (acc_reg > ACC_W'(SUM_MAX));
        sat_sum = sat_ovf ? SUM_MAX : acc_reg[SUM_W-1:0];

        // val * 10 + top octal digit
        conv_val = {val_reg[RESULT_W-4:0], 3'b000} + {val_reg[RESULT_W-2:0], 1'b0}
                 + RESULT_W'(n_reg[3*OUT_DIGITS-1 -: 3]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg   <= res_next;
        func_reg  <= func_next;
        n_reg     <= n_next;
        t_reg     <= t_next;
        acc_reg   <= acc_next;
        digit_reg <= digit_next;
        sh_reg    <= sh_next;
        cnt_reg   <= cnt_next;
        val_reg   <= val_next;
        ovf_reg   <= ovf_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        func_next      = func_reg;
        n_next         = n_reg;
        t_next         = t_reg;
        acc_next       = acc_reg;
        digit_next     = digit_reg;
        sh_next        = sh_reg;
        cnt_next       = cnt_reg;
        val_next       = val_reg;
        ovf_next       = ovf_reg;
        item_ready     = 1'b0;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    func_next  = item.func;
                    n_next     = item.octal_coded;
                    acc_next   = ACC_W'(item.addend);
                    digit_next = 4'd0;
                    sh_next    = '0;
                    cnt_next   = '0;
                    state_next = ST_DIG_A;
                end
            end
            ST_DIG_A:
            begin
                // fold in the digit found last round
                acc_next   = acc_reg + term;
                digit_next = 4'd0;
                if (n_reg == '0 || cnt_reg == CNT_W'(IN_DIGITS))
                begin
                    state_next = ST_SAT;
                end
                else
                begin
                    t_next     = q2;
                    state_next = ST_DIG_B;
                end
            end
            ST_DIG_B:
            begin
                t_next     = q4;
                state_next = ST_DIG_C;
            end
            ST_DIG_C:
            begin
                n_next     = quo + CODED_W'(rem_ge);
                digit_next = dig;
                sh_next    = SH_W'(cnt_reg * 3);
                cnt_next   = cnt_reg + 1'b1;
                state_next = ST_DIG_A;
            end
            ST_SAT:
            begin
                ovf_next = sat_ovf;
                val_next = RESULT_W'(sat_sum);
                if (func_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    n_next     = CODED_W'(sat_sum);
                    val_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                val_next = conv_val;
                n_next   = n_reg << 3;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(OUT_DIGITS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_next.result   = val_reg;
                    res_next.overflow = ovf_reg;
                    res_valid_next    = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

@@ sv/oca_checker.sv @@
// oca_checker: port-level checks for octal_coded_add_convert_unit, with the
// bind that attaches it
// depends on oca_pkg
`timescale 1ns / 1ps
`default_nettype none

module oca_checker
    import oca_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    item_valid,
    input wire logic    item_ready,
    input wire logic    res_valid,
    input wire logic    res_ready,
    input wire result_t res
);

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // one item in work at a time
    a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item taken while another is in work");

    // a saturated result is the largest sum in either form
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.overflow |->
            (res.result == RESULT_W'(SUM_MAX) || res.result == SUM_MAX_CODED))
        else $error("overflow without saturated result");

    a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.result <= SUM_MAX_CODED)
        else $error("result out of range");

endmodule

bind octal_coded_add_convert_unit oca_checker u_oca_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
);

`default_nettype wire

@@ bench/oca_checker.sv @@
// oca_scoreboard: watches both channels of the octal-coded add/convert unit,
// predicts each result from the accepted item and compares it in order
// depends on oca_pkg
`timescale 1ns / 1ps

module oca_scoreboard
    import oca_pkg::*;
#(
    parameter int IN_DIGITS = 10
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    input  wire logic    item_ready,
    input  wire item_t   item,
    input  wire logic    res_valid,
    input  wire logic    res_ready,
    input  wire result_t res,
    output int           errors,
    output int           pending
);

    result_t predicted_sums[$];
    int      err_count = 0;

    // weight the low decimal digits by powers of eight, add, saturate, and
    // optionally write the sum back with one decimal digit per octal digit
    function automatic result_t convert_and_add(item_t it);
        logic [63:0] coded;
        logic [63:0] sum;
        logic [63:0] weight;
        logic [63:0] place;
        logic [63:0] octal_form;
        result_t     r;
        int          i;
        coded  = {30'b0, it.octal_coded};
        sum    = {34'b0, it.addend};
        weight = 64'd1;
        for (i = 0; i < IN_DIGITS; i++)
        begin
            // digits eight and nine are weighted as written
            sum    = sum + (coded % 64'd10) * weight;
            coded  = coded / 64'd10;
            weight = weight * 64'd8;
        end
        r.overflow = 1'b0;
        if (sum > {33'b0, SUM_MAX})
        begin
            sum        = {33'b0, SUM_MAX};
            r.overflow = 1'b1;
        end
        if (it.func)
        begin
            r.result = sum[RESULT_W-1:0];
        end
        else
        begin
            octal_form = 64'd0;
            place      = 64'd1;
            for (i = 0; i < OUT_DIGITS; i++)
            begin
                octal_form = octal_form + (sum % 64'd8) * place;
                sum        = sum / 64'd8;
                place      = place * 64'd10;
            end
            r.result = octal_form[RESULT_W-1:0];
        end
        return r;
    endfunction

    always @(posedge clk)
    begin : monitor
        result_t expected;
        if (rst_n)
        begin
            if (item_valid && item_ready)
            begin
                predicted_sums.push_back(convert_and_add(item));
            end
            if (res_valid && res_ready)
            begin
                if (predicted_sums.size() == 0)
                begin
                    err_count++;
                    $display("%0t unexpected transfer: expected none, actual result %0d overflow %0d",
                             $time, res.result, res.overflow);
                end
                else
                begin
                    expected = predicted_sums.pop_front();
                    if (res.result !== expected.result)
                    begin
                        err_count++;
                        $display("%0t result mismatch: expected %0d, actual %0d",
                                 $time, expected.result, res.result);
                    end
                    if (res.overflow !== expected.overflow)
                    begin
                        err_count++;
                        $display("%0t overflow mismatch: expected %0d, actual %0d",
                                 $time, expected.overflow, res.overflow);
                    end
                end
            end
        end
        errors  <= err_count;
        pending <= predicted_sums.size();
    end

endmodule

@@ bench/tb_octal_coded_add_convert_unit.sv @@
// tb_octal_coded_add_convert_unit: drives directed and random items into the
// octal-coded add/convert unit with bursty input and a stalling receiver
// depends on oca_pkg, octal_coded_add_convert_unit and oca_scoreboard
`timescale 1ns / 1ps

module tb_octal_coded_add_convert_unit
    import oca_pkg::*;
();

    localparam int IN_DIGITS      = 10;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int IDLE_LIMIT     = 5000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int HOLD_AT        = 3000;
    localparam int HOLD_LEN       = 500;
    localparam logic [ADDEND_W-1:0] ADDEND_MAX = '1;

    logic    clk        = 1'b0;
    logic    rst_n      = 1'b0;
    logic    item_valid = 1'b0;
    item_t   item       = '0;
    logic    res_ready  = 1'b0;
    logic    item_ready;
    logic    res_valid;
    result_t res;
    int      errors;
    int      pending;
    int      idle_cycles = 0;

    octal_coded_add_convert_unit #(
        .IN_DIGITS (IN_DIGITS)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    oca_scoreboard #(
        .IN_DIGITS (IN_DIGITS)
    ) u_scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .errors     (errors),
        .pending    (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic item_t make_item(input logic f, input logic [CODED_W-1:0] c,
                                        input logic [ADDEND_W-1:0] a);
        item_t it;
        it.func        = f;
        it.octal_coded = c;
        it.addend      = a;
        return it;
    endfunction

    function automatic item_t random_item();
        item_t       it;
        logic [63:0] acc;
        int          ndig;
        int          top_digit;
        int          i;
        it.func = 1'($urandom_range(0, 1));
        acc     = 64'd0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6:
            begin
                // mostly true octal digits, sometimes eights and nines mixed in
                ndig      = int'($urandom_range(1, IN_DIGITS));
                top_digit = ($urandom_range(0, 2) == 0) ? 9 : 7;
                for (i = 0; i < ndig; i++)
                begin
                    acc = acc * 64'd10 + 64'($urandom_range(0, top_digit));
                end
            end
            7:       acc = {$urandom, $urandom};
            8:       acc = 64'($urandom_range(0, 100));
            default: acc = 64'd7777777770 + 64'($urandom_range(0, 9));
        endcase
        it.octal_coded = acc[CODED_W-1:0];
        case ($urandom_range(0, 5))
            0, 1, 2: it.addend = 30'($urandom);
            3:       it.addend = 30'($urandom_range(0, 255));
            4:       it.addend = ADDEND_MAX - 30'($urandom_range(0, 16));
            default: it.addend = '0;
        endcase
        return it;
    endfunction

    task automatic send_item(input item_t it);
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
    endtask

    // receiver: segments of steady ready, random ready and stalls, plus one
    // long hold-off so the output register fills and the input backs up
    initial
    begin : receiver
        int rx_cycle;
        int seg_len;
        int mode;
        bit held;
        rx_cycle = 0;
        held     = 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (!held && rx_cycle >= HOLD_AT)
            begin
                held = 1'b1;
                res_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
                rx_cycle += HOLD_LEN;
            end
            mode    = $urandom_range(0, 2);
            seg_len = $urandom_range(1, 40);
            repeat (seg_len)
            begin
                case (mode)
                    0:       res_ready <= 1'b1;
                    1:       res_ready <= 1'($urandom_range(0, 1));
                    default: res_ready <= (seg_len > 20) ? 1'b0
                                                         : ($urandom_range(0, 1) == 0);
                endcase
                @(posedge clk);
                rx_cycle++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (res_valid && res_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : stimulus
        item_t directed_items[$];
        int    burst_left;
        int    gap;
        int    n;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero sum with both formats
        directed_items.push_back(make_item(1'b0, 34'd0, 30'd0));
        directed_items.push_back(make_item(1'b1, 34'd0, 30'd0));
        // eights and nines weighted as written
        directed_items.push_back(make_item(1'b0, 34'd9, 30'd0));
        directed_items.push_back(make_item(1'b1, 34'd19, 30'd0));
        directed_items.push_back(make_item(1'b0, 34'd88888888, 30'd5));
        // around the saturation point
        directed_items.push_back(make_item(1'b0, 34'd7777777777, ADDEND_MAX));
        directed_items.push_back(make_item(1'b1, 34'd7777777778, ADDEND_MAX));
        directed_items.push_back(make_item(1'b0, 34'd7777777778, ADDEND_MAX));
        directed_items.push_back(make_item(1'b0, 34'd7777777779, ADDEND_MAX));
        directed_items.push_back(make_item(1'b1, 34'd7777777779, ADDEND_MAX));
        directed_items.push_back(make_item(1'b1, 34'd9999999999, ADDEND_MAX));
        // digits above the converted width are dropped
        directed_items.push_back(make_item(1'b0, 34'd10000000000, 30'd0));
        directed_items.push_back(make_item(1'b0, '1, 30'd0));
        directed_items.push_back(make_item(1'b1, '1, ADDEND_MAX));
        directed_items.push_back(make_item(1'b1, 34'd0, ADDEND_MAX));
        directed_items.push_back(make_item(1'b0, 34'd1, 30'd0));
        directed_items.push_back(make_item(1'b1, 34'd7, 30'd1));
        directed_items.push_back(make_item(1'b0, 34'd1234567012, 30'h2AAA_AAAA));
        directed_items.push_back(make_item(1'b1, 34'h2_AAAA_AAAA, 30'h1555_5555));
        directed_items.push_back(make_item(1'b0, 34'h1_5555_5555, 30'h2AAA_AAAA));

        foreach (directed_items[i])
        begin
            send_item(directed_items[i]);
        end

        // hold the input until every result is back
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end

        burst_left = $urandom_range(1, 40);
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
            begin
                item_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                begin
                    @(posedge clk);
                end
            end
            send_item(random_item());
            burst_left--;
            if (burst_left <= 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                if (gap > 0)
                begin
                    item_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 40);
            end
        end

        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && pending == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
